[src/mlg_pkg.sv]
package mlg_pkg;

  localparam int unsigned SEC_W     = 8;
  localparam int unsigned FIELD_LINES = 4;

  localparam logic [SEC_W-1:0] SEC_MAX        = 8'hFF;
  localparam logic [SEC_W-1:0] WAIT_RESET     = 8'd5;
  localparam logic [SEC_W-1:0] RELAY_RESET    = 8'd5;
  localparam logic [SEC_W-1:0] TPS_RESET      = 8'd20;

  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAIT_SECONDS  = 2'd0,
    CFG_RELAY_SECONDS = 2'd1,
    CFG_TICKS_PER_SEC = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WATCH = 2'd1,
    MODE_AUTH  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [SEC_W-1:0] wait_seconds;
    logic [SEC_W-1:0] relay_seconds;
  } lane_cfg_t;

  typedef struct packed {
    logic  relay;
    mode_t mode;
  } lane_stat_t;

  function automatic logic [SEC_W-1:0] sat_inc(input logic [SEC_W-1:0] v);
    sat_inc = (v == SEC_MAX) ? SEC_MAX : v + 1'b1;
  endfunction

endpackage

[src/mlg_lane.sv]
module mlg_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               sec,
  input  logic               off,
  input  logic               seen,
  input  mlg_pkg::lane_cfg_t cfg,
  output mlg_pkg::lane_stat_t stat
);

  mlg_pkg::mode_t                mode_r, mode_nxt;
  logic                          armed_r, armed_nxt;
  logic                          cutting_r, cutting_nxt;
  logic                          relay_r, relay_nxt;
  logic [mlg_pkg::SEC_W-1:0]     watch_r, watch_nxt;
  logic [mlg_pkg::SEC_W-1:0]     cut_r, cut_nxt;

  always_comb begin
    mode_nxt    = mode_r;
    armed_nxt   = armed_r;
    cutting_nxt = cutting_r;
    relay_nxt   = relay_r;
    watch_nxt   = (armed_r && sec) ? mlg_pkg::sat_inc(watch_r) : watch_r;
    cut_nxt     = (cutting_r && sec) ? mlg_pkg::sat_inc(cut_r) : cut_r;

    if (!off) begin
      mode_nxt    = mlg_pkg::MODE_IDLE;
      armed_nxt   = 1'b0;
      cutting_nxt = 1'b0;
      relay_nxt   = 1'b0;
      watch_nxt   = '0;
      cut_nxt     = '0;
    end else if (mode_r != mlg_pkg::MODE_AUTH) begin
      mode_nxt = mlg_pkg::MODE_WATCH;
      if (!armed_r) begin
        armed_nxt = 1'b1;
        watch_nxt = '0;
      end else if (!cutting_r) begin
        if (seen) begin
          mode_nxt    = mlg_pkg::MODE_AUTH;
          armed_nxt   = 1'b0;
          relay_nxt   = 1'b0;
          watch_nxt   = '0;
          cut_nxt     = '0;
        end else if (watch_nxt >= cfg.wait_seconds) begin
          relay_nxt   = 1'b1;
          cutting_nxt = 1'b1;
          watch_nxt   = '0;
          cut_nxt     = '0;
        end
      end else if (cut_nxt >= cfg.relay_seconds) begin
        mode_nxt    = mlg_pkg::MODE_IDLE;
        armed_nxt   = 1'b0;
        cutting_nxt = 1'b0;
        relay_nxt   = 1'b0;
        watch_nxt   = '0;
        cut_nxt     = '0;
      end
    end
  end

  always_comb begin
    stat.relay = relay_nxt;
    stat.mode  = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= mlg_pkg::MODE_IDLE;
      armed_r   <= 1'b0;
      cutting_r <= 1'b0;
      relay_r   <= 1'b0;
      watch_r   <= '0;
      cut_r     <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      armed_r   <= armed_nxt;
      cutting_r <= cutting_nxt;
      relay_r   <= relay_nxt;
      watch_r   <= watch_nxt;
      cut_r     <= cut_nxt;
    end
  end

  a_relay_tracks_cut: assert property (@(posedge clk) disable iff (!rst_n)
    relay_r == cutting_r) else $error("relay out of step with cut");

  a_cut_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    cutting_r |-> (armed_r && mode_r == mlg_pkg::MODE_WATCH))
    else $error("cut without armed watch");

  a_auth_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == mlg_pkg::MODE_AUTH) |-> (!armed_r && !cutting_r))
    else $error("authorized line not clear");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == mlg_pkg::MODE_IDLE) |-> (!armed_r && !cutting_r))
    else $error("idle line not clear");

endmodule

[src/mlg_out.sv]
module mlg_out #(
  parameter int unsigned LINES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mlg_pkg::lane_stat_t stats [LINES],
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_relay_closed,
  output logic [7:0]          out_line_modes
);

  logic [3:0] relay_new;
  logic [7:0] modes_new;
  logic       out_valid_r, skid_valid_r;
  logic [3:0] relay_r, skid_relay_r;
  logic [7:0] modes_r, skid_modes_r;
  logic       pop;

  genvar g;
  generate
    for (g = 0; g < mlg_pkg::FIELD_LINES; g++) begin : g_pack
      if (g < LINES) begin : g_on
        assign relay_new[g]         = stats[g].relay;
        assign modes_new[2*g+1:2*g] = stats[g].mode;
      end else begin : g_off
        assign relay_new[g]         = 1'b0;
        assign modes_new[2*g+1:2*g] = 2'b00;
      end
    end
  endgenerate

  assign pop      = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        relay_r <= skid_relay_r;
        modes_r <= skid_modes_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        relay_r <= relay_new;
        modes_r <= modes_new;
      end else begin
        skid_relay_r <= relay_new;
        skid_modes_r <= modes_new;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_relay_closed = relay_r;
  assign out_line_modes   = modes_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds beat ahead of output");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid beat lost");

endmodule

[src/line_metering_guard_fsm.sv]
// Metering guard for a bank of phone lines, one lane per line.
// Input channel (in_valid/in_ready): one beat per scan carries the base tick
// flag, the off-hook bits and the metering-detect bits for all lines.
// Result channel (out_valid/out_ready): one beat per input beat carries the
// cut relay bits and two mode bits per line (idle, watching, authorized).
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 wait
// seconds, 1 relay seconds, 2 ticks per second; other indexes are ignored.
// cfg_ready is always high; write only while no beat is in flight.
// Results are registered in the output buffer as their beat is taken.
// Throughput: one beat per cycle while in_ready is high; every lane updates
// its line in the same cycle; a two-entry output buffer packs the lane results.
// When the receiver stalls, one more input beat is taken into the second
// entry; in_ready then drops until the receiver takes a beat.
// Reset (rst_n low, synchronous): all lines idle and released, prescaler at
// zero, registers back to 5 seconds, 5 seconds and 20 ticks per second.
module line_metering_guard_fsm #(
  parameter int unsigned LINES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_base_tick,
  input  logic [3:0] in_hook_off,
  input  logic [3:0] in_metering_seen,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_relay_closed,
  output logic [7:0] out_line_modes,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  mlg_pkg::lane_cfg_t          lane_cfg;
  logic [mlg_pkg::SEC_W-1:0]   wait_r, relay_r, tps_r;
  logic [mlg_pkg::SEC_W-1:0]   prescale_r, prescale_nxt, prescale_inc;
  logic                        sec;
  logic                        step;
  logic                        can_push;
  mlg_pkg::lane_stat_t         stats [LINES];

  assign cfg_ready = 1'b1;
  assign in_ready  = can_push;
  assign step      = in_valid && can_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r  <= mlg_pkg::WAIT_RESET;
      relay_r <= mlg_pkg::RELAY_RESET;
      tps_r   <= mlg_pkg::TPS_RESET;
    end else if (cfg_valid) begin
      case (mlg_pkg::cfg_idx_t'(cfg_index))
        mlg_pkg::CFG_WAIT_SECONDS:  wait_r  <= cfg_data;
        mlg_pkg::CFG_RELAY_SECONDS: relay_r <= cfg_data;
        mlg_pkg::CFG_TICKS_PER_SEC: tps_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lane_cfg.wait_seconds  = wait_r;
  assign lane_cfg.relay_seconds = relay_r;

  assign prescale_inc = prescale_r + 1'b1;
  assign sec          = in_base_tick && (prescale_inc == tps_r);

  always_comb begin
    prescale_nxt = prescale_r;
    if (in_base_tick) begin
      prescale_nxt = sec ? '0 : prescale_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
    end else if (step) begin
      prescale_r <= prescale_nxt;
    end
  end

  genvar g;
  generate
    for (g = 0; g < LINES; g++) begin : g_lane
      logic off, seen;
      if (g < mlg_pkg::FIELD_LINES) begin : g_in
        assign off  = in_hook_off[g];
        assign seen = in_metering_seen[g];
      end else begin : g_none
        assign off  = 1'b0;
        assign seen = 1'b0;
      end
      mlg_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .sec   (sec),
        .off   (off),
        .seen  (seen),
        .cfg   (lane_cfg),
        .stat  (stats[g])
      );
    end
  endgenerate

  mlg_out #(
    .LINES (LINES)
  ) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (step),
    .stats            (stats),
    .can_push         (can_push),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_relay_closed (out_relay_closed),
    .out_line_modes   (out_line_modes)
  );

endmodule
